### rtl/mavg_pkg.sv
// Package for the moving-average filter with remainder compensation.
// Holds field widths, register indexes and the controller-to-datapath command struct.
// No dependencies.
package mavg_pkg;

	localparam int DATA_W         = 32;   // sample and position width
	localparam int SUM_W          = 48;   // running and residual sum width
	localparam int TOTAL_W        = SUM_W + 1;
	localparam int Q_SHIFT        = 15;   // Q15 reciprocal
	localparam int PROD_W         = Q_SHIFT + DATA_W;  // product bits kept
	localparam int LEN_CFG_W      = 13;
	localparam int RECIP_W        = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;
	localparam int DEF_MAX_LENGTH = 4096;

	localparam logic [LEN_CFG_W-1:0] LEN_RESET   = LEN_CFG_W'(1);
	localparam logic [RECIP_W-1:0]   RECIP_RESET = RECIP_W'(32768);

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RECIPROCAL    = 1'b1;

	// one-hot step commands from the controller
	typedef struct packed {
		logic clear;     // clear request accepted
		logic start;     // filter request accepted
		logic sum;       // update running sum, write store
		logic total;     // form residual + running sum
		logic mul_lo;    // low partial product
		logic mul_hi;    // high partial product, extract position
		logic rem;       // position times length
		logic resid;     // accumulate residual
		logic load_out;  // move result into output register
	} cmd_t;

endpackage

### rtl/mavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mavg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/mavg_ctrl.sv
// Controller of the moving-average filter: sequences the steps of one request.
// Depends on mavg_pkg.
module mavg_ctrl
	import mavg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic func,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_TOTAL,
		S_MUL_LO,
		S_MUL_HI,
		S_REM,
		S_RESID,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.clear    = accept && func;
		cmd.start    = accept && !func;
		cmd.sum      = (state_q == S_SUM);
		cmd.total    = (state_q == S_TOTAL);
		cmd.mul_lo   = (state_q == S_MUL_LO);
		cmd.mul_hi   = (state_q == S_MUL_HI);
		cmd.rem      = (state_q == S_REM);
		cmd.resid    = (state_q == S_RESID);
		cmd.load_out = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= func ? S_OUT : S_SUM;
					end
				end
				S_SUM:    state_q <= S_TOTAL;
				S_TOTAL:  state_q <= S_MUL_LO;
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_REM;
				S_REM:    state_q <= S_RESID;
				S_RESID:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/mavg_dp.sv
// Datapath of the moving-average filter: config registers, sums, sample store,
// split multiplier and output register. Depends on mavg_pkg and mavg_ram.
module mavg_dp
	import mavg_pkg::*;
#(
	parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	input  logic [DATA_W-1:0]     sample_in,
	output logic [DATA_W-1:0]     position_out,
	output logic                  window_full
);

	localparam int ADDR_W = $clog2(MAX_LENGTH);
	localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
	localparam int CMP_W  = (CNT_W > LEN_CFG_W) ? CNT_W : LEN_CFG_W;
	localparam logic [CMP_W-1:0] MAX_LEN_C = CMP_W'(MAX_LENGTH);

	logic [LEN_CFG_W-1:0] filter_length_q;
	logic [RECIP_W-1:0]   recip_q;

	logic [SUM_W-1:0]   run_q;
	logic [SUM_W-1:0]   res_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   widx_q;
	logic [CNT_W-1:0]   len_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [DATA_W-1:0]  sample_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SUM_W-1:0]   plo_q;
	logic [DATA_W-1:0]  pos_q;
	logic [SUM_W-1:0]   pl_q;
	logic               full_q;
	logic [DATA_W-1:0]  out_pos_q;
	logic               out_full_q;

	logic [CMP_W-1:0]   len_ext;
	logic [CNT_W-1:0]   len_now;
	logic [ADDR_W-1:0]  idx_now;
	logic [DATA_W-1:0]  old_sample;
	logic [SUM_W-1:0]   old_ext;
	logic [SUM_W-1:0]   new_ext;
	logic               filling;
	logic [29:0]        phi;
	logic [PROD_W-1:0]  psum;

	// saturate the window length to 1..MAX_LENGTH
	assign len_ext = CMP_W'(filter_length_q);
	always_comb begin
		if (filter_length_q == '0) begin
			len_now = CNT_W'(1);
		end else if (len_ext > MAX_LEN_C) begin
			len_now = CNT_W'(MAX_LENGTH);
		end else begin
			len_now = len_ext[CNT_W-1:0];
		end
	end

	// wrap the write index after a length change
	assign idx_now = (widx_q >= len_now) ? '0 : widx_q[ADDR_W-1:0];

	mavg_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_LENGTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.sum),
		.waddr (idx_q),
		.wdata (sample_q),
		.raddr (idx_now),
		.rdata (old_sample)
	);

	assign filling = (fill_q < len_q);
	assign old_ext = {{(SUM_W-DATA_W){old_sample[DATA_W-1]}}, old_sample};
	assign new_ext = {{(SUM_W-DATA_W){sample_q[DATA_W-1]}}, sample_q};
	assign phi     = total_q[PROD_W-1:DATA_W] * recip_q[Q_SHIFT-1:0];
	assign psum    = plo_q[PROD_W-1:0] + {phi[PROD_W-DATA_W-1:0], {DATA_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_length_q <= LEN_RESET;
			recip_q         <= RECIP_RESET;
			run_q           <= '0;
			res_q           <= '0;
			fill_q          <= '0;
			widx_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FILTER_LENGTH: filter_length_q <= cfg_data[LEN_CFG_W-1:0];
					REG_RECIPROCAL:    recip_q         <= cfg_data[RECIP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear) begin
				run_q  <= '0;
				res_q  <= '0;
				fill_q <= '0;
				widx_q <= '0;
			end
			if (cmd.sum) begin
				if (filling) begin
					fill_q <= fill_q + CNT_W'(1);
					run_q  <= run_q + new_ext;
				end else begin
					run_q  <= run_q - old_ext + new_ext;
				end
				widx_q <= CNT_W'(idx_q) + CNT_W'(1);
			end
			if (cmd.resid) begin
				res_q <= res_q + run_q - pl_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sample_q <= sample_in;
			idx_q    <= idx_now;
			len_q    <= len_now;
		end
		if (cmd.clear) begin
			pos_q  <= '0;
			full_q <= 1'b0;
		end
		if (cmd.sum) begin
			full_q <= filling ? ((fill_q + CNT_W'(1)) >= len_q) : 1'b1;
		end
		if (cmd.total) begin
			total_q <= {res_q[SUM_W-1], res_q} + {run_q[SUM_W-1], run_q};
		end
		if (cmd.mul_lo) begin
			plo_q <= total_q[DATA_W-1:0] * recip_q;
		end
		if (cmd.mul_hi) begin
			pos_q <= psum[PROD_W-1:Q_SHIFT];
		end
		if (cmd.rem) begin
			pl_q <= {{(SUM_W-DATA_W){pos_q[DATA_W-1]}}, pos_q} * SUM_W'(len_q);
		end
		if (cmd.load_out) begin
			out_pos_q  <= pos_q;
			out_full_q <= full_q;
		end
	end

	assign position_out = out_pos_q;
	assign window_full  = out_full_q;

endmodule

### rtl/moving_average_remainder_filter.sv
// Moving-average filter with remainder compensation, top level.
// A filter request passes through the store read, sum update, split multiply and
// residual accumulate steps before its result is loaded; a clear request goes
// straight to the output step. A new request is accepted only when idle.
// Reset (arst_n, asynchronous): sums and counters zero, length 1, reciprocal 32768;
// the sample store is not cleared. Depends on mavg_pkg, mavg_ctrl, mavg_dp.
module moving_average_remainder_filter
	import mavg_pkg::*;
#(
	parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [DATA_W-1:0]     s_axis_tdata,   // [31:0] sample_in
	input  logic                  s_axis_tuser,   // [0] func (1 = clear)
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [DATA_W-1:0]     m_axis_tdata,   // [31:0] position_out
	output logic                  m_axis_tuser    // [0] window_full
);

	cmd_t cmd;

	// Sequence each request: accept only when idle, hold the last result in the
	// output register so a new request can start while it waits to be taken.
	mavg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.func      (s_axis_tuser),
		.out_ready (m_axis_tready),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd)
	);

	// Ring store, running and residual sums, two-step multiply by the reciprocal.
	mavg_dp #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sample_in    (s_axis_tdata),
		.position_out (m_axis_tdata),
		.window_full  (m_axis_tuser)
	);

endmodule
